// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/lpht_pkg.sv =====
// Shared types and codes for the linear probe hash table.
`timescale 1ns / 1ps
`default_nettype none
package lpht_pkg;
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam int unsigned MAX_KEY_BYTES = 8;
  // slot count, a power of two matching the 10-bit slot index
  localparam int unsigned TABLE_DEPTH = 1024;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [9:0]  slot_index;
    logic [10:0] probe_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic clr;       // clear one valid flag after reset
    logic load;      // capture request, clear hash
    logic hash_step; // absorb one key byte
    logic hash_fin;  // finalize, set probe to home
    logic rd;        // issue slot read
    logic advance;   // step probe
    logic wr_ins;    // write slot, mark valid
    logic wr_del;    // clear valid
    logic respond;   // emit result
    logic [1:0] rsp_kind;
  } ctl_t;

  localparam logic [1:0] RK_HIT   = 2'd0;
  localparam logic [1:0] RK_STOP  = 2'd1;
  localparam logic [1:0] RK_SWEEP = 2'd2;
  localparam logic [1:0] RK_BAD   = 2'd3;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic clr_last;
    logic hash_last;
    logic hit;
    logic empty;
    logic sweep_end;
  } sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/lpht_ctrl.sv =====
// Sequencer for hash, probe and response steps.
`timescale 1ns / 1ps
`default_nettype none
module lpht_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire lpht_pkg::sts_t sts_i,
  output lpht_pkg::ctl_t      ctl_o,
  output logic                busy_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_BAD  = 3'd5;
  localparam logic [2:0] S_CLR  = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLR;
    else state_q <= state_d;
  end

  always_comb begin
    ctl_o = '0;
    state_d = state_q;
    unique case (state_q)
      S_CLR: begin
        // empty one slot per cycle
        ctl_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (sts_i.op == lpht_pkg::OP_NONE) begin
          state_d = S_BAD;
        end else begin
          ctl_o.hash_step = 1'b1;
          if (sts_i.hash_last) state_d = S_FIN;
        end
      end
      S_FIN: begin
        ctl_o.hash_fin = 1'b1;
        state_d = S_RD;
      end
      S_RD: begin
        ctl_o.rd = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        priority if ((sts_i.op == lpht_pkg::OP_INSERT) && (sts_i.hit || sts_i.empty)) begin
          ctl_o.wr_ins = 1'b1;
          ctl_o.respond = 1'b1;
          ctl_o.rsp_kind = lpht_pkg::RK_HIT;
          state_d = S_IDLE;
        end else if (sts_i.hit) begin
          ctl_o.wr_del = (sts_i.op == lpht_pkg::OP_DELETE);
          ctl_o.respond = 1'b1;
          ctl_o.rsp_kind = lpht_pkg::RK_HIT;
          state_d = S_IDLE;
        end else if ((sts_i.op == lpht_pkg::OP_DELETE) && sts_i.empty) begin
          ctl_o.respond = 1'b1;
          ctl_o.rsp_kind = lpht_pkg::RK_STOP;
          state_d = S_IDLE;
        end else if (sts_i.sweep_end) begin
          ctl_o.respond = 1'b1;
          ctl_o.rsp_kind = lpht_pkg::RK_SWEEP;
          state_d = S_IDLE;
        end else begin
          ctl_o.advance = 1'b1;
          ctl_o.rd = 1'b1;
        end
      end
      S_BAD: begin
        ctl_o.respond = 1'b1;
        ctl_o.rsp_kind = lpht_pkg::RK_BAD;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
endmodule
`default_nettype wire

// ===== hw/rtl/lpht_datapath.sv =====
// Hash unit, probe counter, slot memories and result register.
`timescale 1ns / 1ps
`default_nettype none
module lpht_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lpht_pkg::req_t req_i,
  input  wire logic [3:0]     key_length_i,
  input  wire lpht_pkg::ctl_t ctl_i,
  output lpht_pkg::sts_t      sts_o,
  output logic                done_o,
  output lpht_pkg::rsp_t      rsp_o
);
  localparam int unsigned TABLE_DEPTH = lpht_pkg::TABLE_DEPTH;
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned PW = AW + 1;
  localparam logic [PW-1:0] LAST_PROBE = PW'(TABLE_DEPTH - 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);
  localparam logic [3:0] MAX_LEN = 4'(lpht_pkg::MAX_KEY_BYTES);

  logic [1:0]    op_q;
  logic [63:0]   key_q;
  logic [31:0]   value_q;
  logic [3:0]    len_q;
  logic [2:0]    byte_q;
  logic [31:0]   hash_q;
  logic [AW-1:0] home_q, slot_q;
  logic [PW-1:0] probe_q;
  logic [AW-1:0] clr_q;
  logic          rd_valid_q;
  logic [63:0]   rd_key_q;
  logic [31:0]   rd_value_q;

  logic        valid_mem [TABLE_DEPTH];
  logic [63:0] key_mem [TABLE_DEPTH];
  logic [31:0] val_mem [TABLE_DEPTH];

  logic [3:0]  len_eff;
  logic [63:0] mask;
  logic [31:0] h_a, h_b, f_a, f_b, f_c;
  logic [AW-1:0] home_slot, next_slot;
  logic          vld_we, vld_wd;
  logic [AW-1:0] vld_wa;
  lpht_pkg::rsp_t rsp_d;

  always_comb begin
    len_eff = key_length_i;
    if (len_eff == 4'd0) len_eff = 4'd1;
    if (len_eff > MAX_LEN) len_eff = MAX_LEN;
    mask = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < len_eff) mask[8*i +: 8] = 8'hFF;
    end
  end

  always_comb begin
    h_a = hash_q + {24'd0, key_q[{byte_q, 3'b000} +: 8]};
    h_a = h_a + (h_a << 10);
    h_b = h_a ^ (h_a >> 6);
    f_a = hash_q + (hash_q << 3);
    f_b = f_a ^ (f_a >> 11);
    f_c = f_b + (f_b << 15);
  end

  // depth is a power of two: keep the low hash bits
  assign home_slot = f_c[AW-1:0];
  assign next_slot = (slot_q == LAST_SLOT) ? '0 : slot_q + AW'(1);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q    <= req_i.operation;
      key_q   <= req_i.key & mask;
      value_q <= req_i.value;
      len_q   <= len_eff;
      byte_q  <= '0;
      hash_q  <= '0;
    end
    if (ctl_i.hash_step) begin
      hash_q <= h_b;
      byte_q <= byte_q + 3'd1;
    end
    if (ctl_i.hash_fin) begin
      home_q  <= home_slot;
      slot_q  <= home_slot;
      probe_q <= '0;
    end
    if (ctl_i.advance) begin
      slot_q  <= next_slot;
      probe_q <= probe_q + PW'(1);
    end
  end

  // registered memory read at the probe address
  logic [AW-1:0] rd_addr;
  assign rd_addr = ctl_i.advance ? next_slot : slot_q;

  always_comb begin
    vld_we = ctl_i.clr || ctl_i.wr_ins || ctl_i.wr_del;
    vld_wa = ctl_i.clr ? clr_q : slot_q;
    vld_wd = ctl_i.wr_ins;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      rd_valid_q <= valid_mem[rd_addr];
      rd_key_q   <= key_mem[rd_addr];
      rd_value_q <= val_mem[rd_addr];
    end
    if (ctl_i.wr_ins) begin
      key_mem[slot_q] <= key_q;
      val_mem[slot_q] <= value_q;
    end
    if (vld_we) valid_mem[vld_wa] <= vld_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (ctl_i.clr) clr_q <= clr_q + AW'(1);
  end

  assign sts_o.op        = op_q;
  assign sts_o.clr_last  = (clr_q == LAST_SLOT);
  assign sts_o.hash_last = ({1'b0, byte_q} + 4'd1) == len_q;
  assign sts_o.hit       = rd_valid_q && (rd_key_q == key_q);
  assign sts_o.empty     = !rd_valid_q;
  assign sts_o.sweep_end = (probe_q == LAST_PROBE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= ctl_i.respond;
  end

  always_comb begin
    rsp_d.status      = lpht_pkg::ST_MISS;
    rsp_d.found_value = '0;
    rsp_d.slot_index  = 10'(slot_q);
    rsp_d.probe_count = 11'(probe_q);
    unique case (ctl_i.rsp_kind)
      lpht_pkg::RK_HIT: begin
        rsp_d.status = lpht_pkg::ST_OK;
        if (op_q == lpht_pkg::OP_GET) rsp_d.found_value = rd_value_q;
      end
      lpht_pkg::RK_STOP: rsp_d.status = lpht_pkg::ST_MISS;
      lpht_pkg::RK_SWEEP: begin
        rsp_d.status = (op_q == lpht_pkg::OP_INSERT) ? lpht_pkg::ST_FULL
                                                     : lpht_pkg::ST_MISS;
        rsp_d.slot_index = 10'(home_q);
      end
      default: begin
        rsp_d.status      = lpht_pkg::ST_MISS;
        rsp_d.slot_index  = '0;
        rsp_d.probe_count = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.respond) rsp_o <= rsp_d;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/linear_probe_hash_table.sv =====
// Top level of the linear probe hash table.
//
// Requests enter on req_i at a clock edge where start is high and busy is
// low. Each result word is registered onto rsp_o with done_o high for one
// cycle; the receiver cannot stall it. An accepted request passes through
// the hash steps (one per key byte), the finalize step, the slot read, one
// compare per probed slot and the result register. busy falls in the cycle
// that shows the result, so the next request may be accepted as it ends; no
// request is taken while one is in progress. Insert and delete stop at the
// first empty or matching slot; get stops only on a match, so a get miss
// sweeps all TABLE_DEPTH slots. The single-port slot memory read sets the
// one slot per cycle probe rate. Operation code 3 skips hash and probe and
// returns a miss. key_length is written on the cfg channel (cfg_valid_i,
// cfg_ready_o); the user must write it only while idle, which the block does
// not enforce; it is always ready. Reset sets key_length to 8 and starts a
// clearing pass that empties all TABLE_DEPTH (1024) slots, with busy high.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module linear_probe_hash_table (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire lpht_pkg::req_t req_i,
  output logic                done_o,
  output lpht_pkg::rsp_t      rsp_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [3:0]     cfg_data_i
);
  lpht_pkg::ctl_t ctl;
  lpht_pkg::sts_t sts;
  logic [3:0] key_length_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) key_length_q <= 4'd8;
    else if (cfg_valid_i && cfg_ready_o) key_length_q <= cfg_data_i;
  end

  lpht_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts), .ctl_o(ctl), .busy_o(busy)
  );

  lpht_datapath u_dp (
    .clk_i, .rst_ni, .req_i, .key_length_i(key_length_q), .ctl_i(ctl),
    .sts_o(sts), .done_o, .rsp_o
  );

  `ASSERT_NEXT(a_respond_done, clk_i, rst_ni, ctl.respond, done_o)
  `ASSERT_IMPL(a_one_write, clk_i, rst_ni, !(ctl.wr_ins && ctl.wr_del))
  `ASSERT_NEXT(a_done_idle, clk_i, rst_ni, ctl.respond, !busy)
  `ASSERT_IMPL(a_load_idle, clk_i, rst_ni, ctl.load |-> !busy)
endmodule
`default_nettype wire
